[hdl/alsd_pkg.sv]
// Package for the ambient light smoothing block: payload structs, codes, sizes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package alsd_pkg;
  localparam int FRAC_BITS = 16;
  localparam int LUX_BITS  = 16;
  localparam int AVG_W     = FRAC_BITS + LUX_BITS;
  localparam int DIV_STEPS = FRAC_BITS + 1;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_START  = 2'd2;
  localparam logic [1:0] CMD_STOP   = 2'd3;

  localparam logic [2:0] REG_FAST_K = 3'd0;
  localparam logic [2:0] REG_SLOW_K = 3'd1;
  localparam logic [2:0] REG_HYST   = 3'd2;
  localparam logic [2:0] REG_MINH   = 3'd3;
  localparam logic [2:0] REG_DELAY  = 3'd4;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] light_lux;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [31:0] light_level;
    logic        first_after_start;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_MULF, ST_MULS, ST_BAND1, ST_DECIDE, ST_BAND2, ST_REARM
  } state_t;
endpackage
`default_nettype wire

[hdl/ambient_light_smoothing_debounce.sv]
// Ambient light smoothing with debounce: top level, sequencer and shared units.
// Depends on alsd_pkg.
//
// One item at a time. Start, stop, ignored items and the first sample after
// start are done when accepted; the first sample's result is registered
// at that edge. Every later sample, and a tick at or past the deadline, runs
// the shared restoring divider once per average, one quotient bit per cycle
// (a quotient of FRAC_BITS+1 bits per factor), then one shared multiply per
// average. A tick adds a band evaluation, the decision, a second band
// evaluation and the re-arm check; its result, only if the decision moves the
// level, is registered in the decision state. in_ready is low while busy, and
// while a result waits in the output register with out_ready low.
`timescale 1ns / 1ps
`default_nettype none
module ambient_light_smoothing_debounce (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire alsd_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output alsd_pkg::out_item_t       out_data,
  input  wire logic                 cfg_we,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [15:0]          cfg_wdata
);
  localparam int AW = alsd_pkg::AVG_W;
  localparam int FB = alsd_pkg::FRAC_BITS;
  localparam int LB = alsd_pkg::LUX_BITS;
  localparam int NW = 33;      // divisor width (dt + K)
  localparam int CW = $clog2(alsd_pkg::DIV_STEPS + 1);

  logic [15:0] fast_k_r, slow_k_r, minh_r, delay_r;
  logic [7:0]  hyst_r;

  logic running_r, have_r, armed_r;
  logic [31:0] last_ms_r, deadline_r;
  logic [LB-1:0] last_lux_r;
  logic [AW-1:0] fast_r, slow_r, applied_r;

  alsd_pkg::state_t state_r, state_nxt;
  logic tick_r;                 // item in progress is a tick
  logic [31:0] now_r;
  logic [32:0] dt_r;
  logic [NW-1:0] den_r;
  logic [NW-1:0] rem_r;         // partial remainder, below den_r when den_r is nonzero
  logic [FB:0] dvd_r;           // dividend bits still to shift in
  logic [FB:0] quo_r;
  logic [CW-1:0] cnt_r;
  logic        slow_pass_r;     // divider works on slow average
  logic [FB-1:0] ff_r, fs_r;
  logic [AW+8-1:0] band_r;
  logic        out_valid_r;
  alsd_pkg::out_item_t out_r;

  assign in_ready  = (state_r == alsd_pkg::ST_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  wire accept = in_valid && in_ready;

  // Decode the accepted item
  logic [31:0] gap_dt, gap_dl;
  logic take_first, take_update;
  assign gap_dt = in_data.now_ms - last_ms_r;
  assign gap_dl = in_data.now_ms - deadline_r;
  assign take_first = accept && running_r && !have_r &&
                      (in_data.command == alsd_pkg::CMD_SAMPLE);
  // deadline passed while now - deadline, mod 2^32, stays below 2^31
  assign take_update = accept && running_r &&
                       (((in_data.command == alsd_pkg::CMD_SAMPLE) && have_r) ||
                        ((in_data.command == alsd_pkg::CMD_TICK) && armed_r &&
                         !gap_dl[31]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_k_r <= 16'd200; slow_k_r <= 16'd2000; hyst_r <= 8'd26;
      minh_r <= 16'd2; delay_r <= 16'd4000;
    end else if (cfg_we) begin
      case (cfg_index)
        alsd_pkg::REG_FAST_K: fast_k_r <= cfg_wdata;
        alsd_pkg::REG_SLOW_K: slow_k_r <= cfg_wdata;
        alsd_pkg::REG_HYST:   hyst_r   <= cfg_wdata[7:0];
        alsd_pkg::REG_MINH:   minh_r   <= cfg_wdata;
        alsd_pkg::REG_DELAY:  delay_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Shared divider step: the dividend is dt << FB, so start from dt >> 1 and
  // shift in dt[0] followed by FB zeros.
  logic [NW:0]   rem_sh;
  logic [NW+1:0] rem_try;
  assign rem_sh  = {rem_r, dvd_r[FB]};
  assign rem_try = {1'b0, rem_sh} - {2'b00, den_r};

  // Shared multiplier: magnitude times factor
  logic [AW-1:0] mul_avg, mul_x;
  logic [FB-1:0] mul_f;
  logic [AW-1:0] mag, step, smoothed;
  logic [AW+FB-1:0] prod;
  assign mul_x = {last_lux_r, {FB{1'b0}}};
  assign mul_avg = slow_pass_r ? slow_r : fast_r;
  assign mul_f = slow_pass_r ? fs_r : ff_r;
  assign mag = (mul_x >= mul_avg) ? (mul_x - mul_avg) : (mul_avg - mul_x);
  assign prod = mag * mul_f;
  assign step = prod[AW+FB-1:FB];
  assign smoothed = (mul_x >= mul_avg) ? (mul_avg + step) : (mul_avg - step);

  // Shared band unit: max(level*hyst/256, minh<<FB)
  logic [AW-1:0] band_lvl;
  logic [AW+8-1:0] band_rel, band_lo, band_val;
  assign band_lvl = (state_r == alsd_pkg::ST_BAND1) ? applied_r : mul_x;
  assign band_rel = (band_lvl * hyst_r) >> 8;
  assign band_lo  = {{(AW+8-16-FB){1'b0}}, minh_r, {FB{1'b0}}};
  assign band_val = (band_rel > band_lo) ? band_rel : band_lo;

  logic [AW:0] sd, fd, nsd, nfd, dx;
  assign sd  = {1'b0, slow_r} - {1'b0, applied_r};
  assign fd  = {1'b0, fast_r} - {1'b0, applied_r};
  assign nsd = -sd;
  assign nfd = -fd;
  assign dx  = (fast_r >= mul_x) ? {1'b0, fast_r - mul_x} : {1'b0, mul_x - fast_r};

  function automatic logic ge_band(input logic [AW:0] d, input logic [AW+8-1:0] b);
    logic [AW+9:0] dd;
    dd = {{9{d[AW]}}, d};
    ge_band = !d[AW] && (dd >= {2'b00, b});
  endfunction

  logic move_ok;
  assign move_ok = (ge_band(sd, band_r) && ge_band(fd, band_r)) ||
                   (ge_band(nsd, band_r) && ge_band(nfd, band_r));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      alsd_pkg::ST_IDLE:
        if (take_update) state_nxt = alsd_pkg::ST_DIV;
      alsd_pkg::ST_DIV:
        if (cnt_r == CW'(alsd_pkg::DIV_STEPS - 1))
          state_nxt = slow_pass_r ? alsd_pkg::ST_MULF : alsd_pkg::ST_DIV;
      alsd_pkg::ST_MULF:   state_nxt = alsd_pkg::ST_MULS;
      alsd_pkg::ST_MULS:   state_nxt = tick_r ? alsd_pkg::ST_BAND1 : alsd_pkg::ST_IDLE;
      alsd_pkg::ST_BAND1:  state_nxt = alsd_pkg::ST_DECIDE;
      alsd_pkg::ST_DECIDE: state_nxt = alsd_pkg::ST_BAND2;
      alsd_pkg::ST_BAND2:  state_nxt = alsd_pkg::ST_REARM;
      alsd_pkg::ST_REARM:  state_nxt = alsd_pkg::ST_IDLE;
      default:             state_nxt = alsd_pkg::ST_IDLE;
    endcase
  end

  logic [FB:0] q_fin;
  logic [FB-1:0] f_sat;
  always_comb begin
    q_fin = {quo_r[FB-1:0], !rem_try[NW+1]};
    if (den_r == '0) f_sat = '0;
    else if (q_fin[FB]) f_sat = {FB{1'b1}};
    else f_sat = q_fin[FB-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= alsd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      running_r <= 1'b0; have_r <= 1'b0; armed_r <= 1'b0;
      last_ms_r <= '0; deadline_r <= '0; last_lux_r <= '0;
      fast_r <= '0; slow_r <= '0; applied_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= take_first || ((state_r == alsd_pkg::ST_DECIDE) && move_ok) ||
                     (out_valid_r && !out_ready);
      case (state_r)
        alsd_pkg::ST_IDLE:
          if (accept) begin
            now_r <= in_data.now_ms;
            if (take_update) begin
              tick_r <= (in_data.command == alsd_pkg::CMD_TICK);
              dt_r <= {1'b0, gap_dt};
              den_r <= {1'b0, gap_dt} + {17'd0, fast_k_r};
              rem_r <= {2'b00, gap_dt[31:1]};
              dvd_r <= {gap_dt[0], {FB{1'b0}}};
              quo_r <= '0; cnt_r <= '0; slow_pass_r <= 1'b0;
            end
            case (in_data.command)
              alsd_pkg::CMD_START:
                if (!running_r) begin
                  running_r <= 1'b1; have_r <= 1'b0; armed_r <= 1'b0;
                  last_ms_r <= '0; deadline_r <= '0; last_lux_r <= '0;
                  fast_r <= '0; slow_r <= '0; applied_r <= '0;
                end
              alsd_pkg::CMD_STOP:
                if (running_r) begin
                  running_r <= 1'b0; have_r <= 1'b0; armed_r <= 1'b0;
                  last_ms_r <= '0; deadline_r <= '0; last_lux_r <= '0;
                  fast_r <= '0; slow_r <= '0; applied_r <= '0;
                end
              alsd_pkg::CMD_SAMPLE:
                if (running_r) begin
                  last_lux_r <= in_data.light_lux;
                  last_ms_r <= in_data.now_ms;
                  have_r <= 1'b1;
                  if (!have_r) begin
                    fast_r <= {in_data.light_lux, {FB{1'b0}}};
                    slow_r <= {in_data.light_lux, {FB{1'b0}}};
                    applied_r <= {in_data.light_lux, {FB{1'b0}}};
                    out_r.light_level <= {in_data.light_lux, {FB{1'b0}}};
                    out_r.first_after_start <= 1'b1;
                  end else if (!armed_r) begin
                    armed_r <= 1'b1;
                    deadline_r <= in_data.now_ms + {16'd0, delay_r};
                  end
                end
              alsd_pkg::CMD_TICK:
                if (take_update) begin
                  armed_r <= 1'b0;
                  last_ms_r <= in_data.now_ms;
                end
              default: ;
            endcase
          end
        alsd_pkg::ST_DIV:
          if (cnt_r == CW'(alsd_pkg::DIV_STEPS - 1)) begin
            if (!slow_pass_r) begin
              ff_r <= f_sat;
              slow_pass_r <= 1'b1;
              den_r <= dt_r + {17'd0, slow_k_r};
              rem_r <= {1'b0, dt_r[32:1]};
              dvd_r <= {dt_r[0], {FB{1'b0}}};
              quo_r <= '0; cnt_r <= '0;
            end else begin
              fs_r <= f_sat;
              slow_pass_r <= 1'b0;
            end
          end else begin
            dvd_r <= {dvd_r[FB-1:0], 1'b0};
            rem_r <= rem_try[NW+1] ? rem_sh[NW-1:0] : rem_try[NW-1:0];
            quo_r <= q_fin;
            cnt_r <= cnt_r + 1'b1;
          end
        alsd_pkg::ST_MULF: begin
          fast_r <= smoothed;
          slow_pass_r <= 1'b1;
        end
        alsd_pkg::ST_MULS: begin
          slow_r <= smoothed;
          slow_pass_r <= 1'b0;
        end
        alsd_pkg::ST_BAND1: band_r <= band_val;
        alsd_pkg::ST_DECIDE:
          if (move_ok) begin
            applied_r <= fast_r;
            out_r.light_level <= fast_r;
            out_r.first_after_start <= 1'b0;
          end
        alsd_pkg::ST_BAND2: band_r <= band_val;
        alsd_pkg::ST_REARM:
          if ({8'd0, dx} >= {1'b0, band_r} && !armed_r) begin
            armed_r <= 1'b1;
            deadline_r <= now_r + {16'd0, delay_r};
          end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
